FILE: rtl/tad_pkg.sv
// ----------------------------------------------------------------------------
// Teletext attribute decoder package
// Shared constants, the cell descriptor type and the mosaic row function.
// ----------------------------------------------------------------------------
`default_nettype none

package tad_pkg;

  localparam int COLUMNS = 40;
  localparam int ROWS    = 25;

  localparam logic [7:0] CODE_FLAG      = 8'h80;
  localparam logic [7:0] CODE_DBL_ON    = 8'd141;
  localparam logic [7:0] CODE_DBL_OFF   = 8'd140;
  localparam logic [7:0] CODE_FLASH     = 8'd136;
  localparam logic [7:0] CODE_STEADY    = 8'd137;
  localparam logic [7:0] CODE_CONCEAL   = 8'd152;
  localparam logic [7:0] CODE_CONTIG    = 8'd153;
  localparam logic [7:0] CODE_SEPARATED = 8'd154;
  localparam logic [7:0] CODE_NEW_BG    = 8'd157;
  localparam logic [7:0] CODE_HOLD      = 8'd158;
  localparam logic [7:0] CODE_RELEASE   = 8'd159;
  localparam logic [7:0] CODE_ALPHA_LO  = 8'd129;
  localparam logic [7:0] CODE_ALPHA_HI  = 8'd135;
  localparam logic [7:0] CODE_GFX_LO    = 8'd145;
  localparam logic [7:0] CODE_GFX_HI    = 8'd151;

  localparam logic [6:0] CHAR_SPACE = 7'd32;

  localparam logic [7:0] MASK_CONTIG    = 8'hFF;
  localparam logic [7:0] MASK_SEPARATED = 8'hEE;
  localparam logic [7:0] LEFT_HALF      = 8'd240;
  localparam logic [7:0] RIGHT_HALF     = 8'd15;

  typedef struct packed {
    logic [2:0] fg;
    logic [2:0] bg;
    logic       flash;
    logic       mosaic;
    logic [6:0] wc;
    logic       dbl;
    logic       lower;
    logic       contig;
    logic [5:0] col;
    logic [4:0] row;
  } desc_t;

  function automatic logic [7:0] mosaic_line(input logic [6:0] ch, input logic [2:0] r,
                                             input logic contig);
    logic [7:0] mask;
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
    logic [7:0] res;
    mask = contig ? MASK_CONTIG : MASK_SEPARATED;
    top  = (ch[0] ? LEFT_HALF : 8'd0) | (ch[1] ? RIGHT_HALF : 8'd0);
    mid  = (ch[2] ? LEFT_HALF : 8'd0) | (ch[3] ? RIGHT_HALF : 8'd0);
    bot  = (ch[4] ? LEFT_HALF : 8'd0) | (ch[6] ? RIGHT_HALF : 8'd0);
    case (r)
      3'd0, 3'd1: res = top & mask;
      3'd2:       res = contig ? (top & mask) : 8'd0;
      3'd3:       res = mid & mask;
      3'd4:       res = contig ? (mid & mask) : 8'd0;
      3'd5, 3'd6: res = bot & mask;
      default:    res = contig ? (bot & mask) : 8'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tad_front.sv
// ----------------------------------------------------------------------------
// Teletext attribute decoder front end
// Accepts character bytes, tracks the serial attributes and the cell position
// and produces one cell descriptor per character.
// ----------------------------------------------------------------------------
`default_nettype none

module tad_front
  import tad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [7:0] char_byte,
  output logic            wr,
  output desc_t           wr_desc
);

  logic [5:0] column_count, column_count_next;
  logic [4:0] row_count, row_count_next;
  logic [2:0] fore_index, fore_index_next;
  logic [2:0] back_index, back_index_next;
  logic       graphics_mode, graphics_mode_next;
  logic       contiguous_mode, contiguous_mode_next;
  logic       conceal_mode, conceal_mode_next;
  logic       double_height_mode, double_height_mode_next;
  logic       hold_mode, hold_mode_next;
  logic       flash_mode, flash_mode_next;
  logic [6:0] held_mosaic, held_mosaic_next;
  logic       row_used_double, row_used_double_next;
  logic       lower_half, lower_half_next;

  logic [7:0] code;
  logic [6:0] wc;
  logic       mosaic;
  logic [6:0] col_inc;
  logic [5:0] row_inc;

  assign wr   = push && !full;
  assign code = char_byte | CODE_FLAG;

  always_comb begin
    fore_index_next         = fore_index;
    back_index_next         = back_index;
    graphics_mode_next      = graphics_mode;
    contiguous_mode_next    = contiguous_mode;
    conceal_mode_next       = conceal_mode;
    double_height_mode_next = double_height_mode;
    hold_mode_next          = hold_mode;
    flash_mode_next         = flash_mode;
    row_used_double_next    = row_used_double;
    if (code >= CODE_ALPHA_LO && code <= CODE_ALPHA_HI) begin
      graphics_mode_next = 1'b0;
      fore_index_next    = code[2:0];
      conceal_mode_next  = 1'b0;
    end
    if (code >= CODE_GFX_LO && code <= CODE_GFX_HI) begin
      graphics_mode_next = 1'b1;
      fore_index_next    = code[2:0];
      conceal_mode_next  = 1'b0;
    end
    if (code == CODE_NEW_BG) back_index_next = fore_index_next;
    if (code == CODE_DBL_ON) begin
      double_height_mode_next = 1'b1;
      row_used_double_next    = 1'b1;
    end
    if (code == CODE_DBL_OFF) double_height_mode_next = 1'b0;
    if (code == CODE_FLASH) flash_mode_next = 1'b1;
    if (code == CODE_STEADY) flash_mode_next = 1'b0;
    if (code == CODE_CONTIG) contiguous_mode_next = 1'b1;
    if (code == CODE_SEPARATED) contiguous_mode_next = 1'b0;
    if (code == CODE_CONCEAL) conceal_mode_next = 1'b1;
    if (code == CODE_HOLD) hold_mode_next = 1'b1;
    if (code == CODE_RELEASE) hold_mode_next = 1'b0;

    wc = code[6:0];
    if (wc >= CHAR_SPACE && conceal_mode_next) wc = CHAR_SPACE;
    if (wc < CHAR_SPACE) wc = hold_mode_next ? held_mosaic : CHAR_SPACE;

    mosaic = graphics_mode_next &&
             ((wc >= 7'd33 && wc <= 7'd63) || (wc >= 7'd95));
    held_mosaic_next = mosaic ? wc : held_mosaic;

    wr_desc.fg     = fore_index_next;
    wr_desc.bg     = back_index_next;
    wr_desc.flash  = flash_mode_next;
    wr_desc.mosaic = mosaic;
    wr_desc.wc     = wc;
    wr_desc.dbl    = double_height_mode_next;
    wr_desc.lower  = lower_half;
    wr_desc.contig = contiguous_mode_next;
    wr_desc.col    = column_count;
    wr_desc.row    = row_count;

    col_inc            = {1'b0, column_count} + 7'd1;
    row_inc            = {1'b0, row_count} + 6'd1;
    column_count_next  = col_inc[5:0];
    row_count_next     = row_count;
    lower_half_next    = lower_half;
    if (col_inc >= 7'(COLUMNS)) begin
      column_count_next       = 6'd0;
      lower_half_next         = row_used_double_next ? !lower_half : 1'b0;
      fore_index_next         = 3'd7;
      back_index_next         = 3'd0;
      graphics_mode_next      = 1'b0;
      contiguous_mode_next    = 1'b1;
      conceal_mode_next       = 1'b0;
      double_height_mode_next = 1'b0;
      hold_mode_next          = 1'b0;
      flash_mode_next         = 1'b0;
      held_mosaic_next        = CHAR_SPACE;
      row_used_double_next    = 1'b0;
      if (row_inc >= 6'(ROWS)) begin
        row_count_next  = 5'd0;
        lower_half_next = 1'b0;
      end else begin
        row_count_next = row_inc[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count       <= 6'd0;
      row_count          <= 5'd0;
      fore_index         <= 3'd7;
      back_index         <= 3'd0;
      graphics_mode      <= 1'b0;
      contiguous_mode    <= 1'b1;
      conceal_mode       <= 1'b0;
      double_height_mode <= 1'b0;
      hold_mode          <= 1'b0;
      flash_mode         <= 1'b0;
      held_mosaic        <= CHAR_SPACE;
      row_used_double    <= 1'b0;
      lower_half         <= 1'b0;
    end else if (wr) begin
      column_count       <= column_count_next;
      row_count          <= row_count_next;
      fore_index         <= fore_index_next;
      back_index         <= back_index_next;
      graphics_mode      <= graphics_mode_next;
      contiguous_mode    <= contiguous_mode_next;
      conceal_mode       <= conceal_mode_next;
      double_height_mode <= double_height_mode_next;
      hold_mode          <= hold_mode_next;
      flash_mode         <= flash_mode_next;
      held_mosaic        <= held_mosaic_next;
      row_used_double    <= row_used_double_next;
      lower_half         <= lower_half_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tad_fifo.sv
// ----------------------------------------------------------------------------
// Teletext attribute decoder descriptor queue
// Two-entry queue of cell descriptors between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tad_fifo
  import tad_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  wire desc_t wr_desc,
  output logic       full,
  input  wire logic  rd,
  output logic       rd_valid,
  output desc_t      rd_desc
);

  desc_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_desc  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) entries[wr_ptr] <= wr_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tad_back.sv
// ----------------------------------------------------------------------------
// Teletext attribute decoder back end
// Expands one cell descriptor into eight scanline words.
// ----------------------------------------------------------------------------
`default_nettype none

module tad_back
  import tad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  input  wire desc_t      in_desc,
  output logic            take,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      fg_colour,
  output logic [2:0]      bg_colour,
  output logic            hide_fore,
  output logic            use_mosaic,
  output logic [7:0]      mosaic_row,
  output logic [6:0]      glyph_code,
  output logic [2:0]      glyph_row,
  output logic [2:0]      scan_row,
  output logic [5:0]      cell_column,
  output logic [4:0]      cell_row,
  output logic            last
);

  desc_t      cur;
  logic       busy;
  logic [2:0] scan;
  logic       flash_phase;
  logic [2:0] gr;
  logic       done;

  assign done  = pop && busy && (scan == 3'd7);
  assign take  = in_valid && (!busy || done);
  assign empty = !busy;
  assign gr    = cur.dbl ? {cur.lower, scan[2:1]} : scan;

  assign fg_colour   = cur.fg;
  assign bg_colour   = cur.bg;
  assign hide_fore   = cur.flash && flash_phase;
  assign use_mosaic  = cur.mosaic;
  assign mosaic_row  = cur.mosaic ? mosaic_line(cur.wc, gr, cur.contig) : 8'd0;
  assign glyph_code  = cur.mosaic ? 7'd0 : cur.wc;
  assign glyph_row   = gr;
  assign scan_row    = scan;
  assign cell_column = cur.col;
  assign cell_row    = cur.row;
  assign last        = (scan == 3'd7);

  always_ff @(posedge clk) begin
    if (take) cur <= in_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      scan        <= 3'd0;
      flash_phase <= 1'b0;
    end else begin
      if (cfg_we) flash_phase <= cfg_data;
      if (take) begin
        busy <= 1'b1;
        scan <= 3'd0;
      end else if (done) begin
        busy <= 1'b0;
        scan <= 3'd0;
      end else if (pop && busy) begin
        scan <= scan + 3'd1;
      end
    end
  end

  a_idle_scan_zero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> scan == 3'd0)
    else $error("scan counter not cleared while idle");

  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    (busy && pop && scan != 3'd7) |=> busy && scan == $past(scan) + 3'd1)
    else $error("scanline word did not advance after pop");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && !pop) |=> busy && $stable(scan) && $stable(cur))
    else $error("waiting word changed without pop");

  a_done_reload: assert property (@(posedge clk) disable iff (rst)
    (done && !in_valid) |=> !busy)
    else $error("back end stayed busy after last word with no descriptor");

endmodule

`default_nettype wire

FILE: rtl/teletext_attribute_decoder.sv
// ----------------------------------------------------------------------------
// Teletext attribute decoder
// Serial attribute decoder producing eight scanline words per character.
// ----------------------------------------------------------------------------
// Each pushed character byte produces eight scanline words in the back end,
// one per cycle while pop is held. The front end decodes attributes in the
// cycle of the push and places a cell descriptor in a two-entry queue, so up
// to two characters may be pushed ahead of the words being drained.
// flash_phase is written through cfg_we and cfg_data into a register in the
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module teletext_attribute_decoder
  import tad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      fg_colour,
  output logic [2:0]      bg_colour,
  output logic            hide_fore,
  output logic            use_mosaic,
  output logic [7:0]      mosaic_row,
  output logic [6:0]      glyph_code,
  output logic [2:0]      glyph_row,
  output logic [2:0]      scan_row,
  output logic [5:0]      cell_column,
  output logic [4:0]      cell_row,
  output logic            last
);

  logic  wr;
  desc_t wr_desc;
  logic  rd;
  logic  rd_valid;
  desc_t rd_desc;

  tad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_byte (char_byte),
    .wr        (wr),
    .wr_desc   (wr_desc)
  );

  tad_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_desc  (wr_desc),
    .full     (full),
    .rd       (rd),
    .rd_valid (rd_valid),
    .rd_desc  (rd_desc)
  );

  tad_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (rd_valid),
    .in_desc     (rd_desc),
    .take        (rd),
    .empty       (empty),
    .pop         (pop),
    .fg_colour   (fg_colour),
    .bg_colour   (bg_colour),
    .hide_fore   (hide_fore),
    .use_mosaic  (use_mosaic),
    .mosaic_row  (mosaic_row),
    .glyph_code  (glyph_code),
    .glyph_row   (glyph_row),
    .scan_row    (scan_row),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .last        (last)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Teletext attribute decoder testbench
// Feeds character bytes through the push side and checks every scanline word
// against a predictor of the serial attribute state. A short table of
// directed characters runs first, followed by random characters under several
// handshake pressure settings. The flash phase register changes between
// phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import tad_pkg::*;
();

  localparam logic [7:0] CODE_ALPHA_BLACK = 8'd128;
  localparam logic [7:0] CODE_GFX_BLACK   = 8'd144;
  localparam logic [7:0] CODE_BLACK_BG    = 8'd156;
  localparam int         DRAIN_CYCLES     = 16;
  localparam int         REPORT_LIMIT     = 10;
  localparam int         NDIR             = 29;
  localparam int         RANDOM_PER_PHASE = 25;

  typedef struct packed {
    logic [2:0] fg;
    logic [2:0] bg;
    logic       hide;
    logic       mos;
    logic [7:0] pix;
    logic [6:0] glyph;
    logic [2:0] grow;
    logic [2:0] srow;
    logic [5:0] col;
    logic [4:0] row;
    logic       last;
  } scan_word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [2:0] fg;
    logic [2:0] bg;
    logic       mos;
    logic [6:0] glyph;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_data;
  logic       push;
  logic       full;
  logic [7:0] char_byte;
  logic       empty;
  logic       pop;
  logic [2:0] fg_colour;
  logic [2:0] bg_colour;
  logic       hide_fore;
  logic       use_mosaic;
  logic [7:0] mosaic_row;
  logic [6:0] glyph_code;
  logic [2:0] glyph_row;
  logic [2:0] scan_row;
  logic [5:0] cell_column;
  logic [4:0] cell_row;
  logic       last;

  logic       typed_en;
  dir_row_t   typed_row;

  scan_word_t pending_words[$];
  scan_word_t got_word;
  scan_word_t exp_word;
  int         mismatch_cnt;
  int         send_idle;
  int         recv_stall;
  dir_row_t   dir_tab [NDIR];
  int         send_pct [4];
  int         recv_pct [4];

  logic [5:0] col_q;
  logic [4:0] row_q;
  logic [2:0] fg_q;
  logic [2:0] bg_q;
  logic       gfx_q;
  logic       contig_q;
  logic       conceal_q;
  logic       dbl_q;
  logic       hold_q;
  logic       flash_q;
  logic [6:0] held_q;
  logic       row_dbl_q;
  logic       lower_q;
  logic       phase_q;

  teletext_attribute_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .char_byte  (char_byte),
    .empty      (empty),
    .pop        (pop),
    .fg_colour  (fg_colour),
    .bg_colour  (bg_colour),
    .hide_fore  (hide_fore),
    .use_mosaic (use_mosaic),
    .mosaic_row (mosaic_row),
    .glyph_code (glyph_code),
    .glyph_row  (glyph_row),
    .scan_row   (scan_row),
    .cell_column(cell_column),
    .cell_row   (cell_row),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic dir_row_t plain(input logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.b = b;
    return r;
  endfunction

  function automatic dir_row_t typed(input logic [7:0] b, input logic [2:0] fg,
                                     input logic [2:0] bg, input logic [6:0] glyph);
    dir_row_t r;
    r.b = b;
    r.typed = 1'b1;
    r.fg = fg;
    r.bg = bg;
    r.mos = 1'b0;
    r.glyph = glyph;
    return r;
  endfunction

  function automatic logic [7:0] sixel_row(input logic [6:0] ch, input logic [2:0] r,
                                           input logic contig);
    logic left;
    logic right;
    logic [7:0] pix;
    if (r < 3'd3) begin
      left = ch[0];
      right = ch[1];
    end else if (r < 3'd5) begin
      left = ch[2];
      right = ch[3];
    end else begin
      left = ch[4];
      right = ch[6];
    end
    pix = {{4{left}}, {4{right}}};
    if (!contig) begin
      pix = pix & MASK_SEPARATED;
      if (r == 3'd2 || r == 3'd4 || r == 3'd7) pix = 8'd0;
    end
    return pix;
  endfunction

  task automatic clear_row_attrs();
    fg_q = 3'd7;
    bg_q = 3'd0;
    gfx_q = 1'b0;
    contig_q = 1'b1;
    conceal_q = 1'b0;
    dbl_q = 1'b0;
    hold_q = 1'b0;
    flash_q = 1'b0;
    held_q = CHAR_SPACE;
    row_dbl_q = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] b, input logic use_typed, input dir_row_t tv);
    logic [7:0] code;
    logic [6:0] wc;
    logic       mos;
    logic [2:0] sr;
    scan_word_t w;
    code = b | CODE_FLAG;
    wc = code[6:0];
    if (code >= CODE_ALPHA_LO && code <= CODE_ALPHA_HI) begin
      gfx_q = 1'b0;
      fg_q = code[2:0];
      conceal_q = 1'b0;
    end
    if (code >= CODE_GFX_LO && code <= CODE_GFX_HI) begin
      gfx_q = 1'b1;
      fg_q = code[2:0];
      conceal_q = 1'b0;
    end
    case (code)
      CODE_NEW_BG:    bg_q = fg_q;
      CODE_DBL_ON: begin
        dbl_q = 1'b1;
        row_dbl_q = 1'b1;
      end
      CODE_DBL_OFF:   dbl_q = 1'b0;
      CODE_FLASH:     flash_q = 1'b1;
      CODE_STEADY:    flash_q = 1'b0;
      CODE_CONTIG:    contig_q = 1'b1;
      CODE_SEPARATED: contig_q = 1'b0;
      CODE_CONCEAL:   conceal_q = 1'b1;
      CODE_HOLD:      hold_q = 1'b1;
      CODE_RELEASE:   hold_q = 1'b0;
      default: ;
    endcase
    if (wc >= 7'd32 && conceal_q) wc = CHAR_SPACE;
    if (wc < 7'd32) wc = hold_q ? held_q : CHAR_SPACE;
    mos = gfx_q && ((wc >= 7'd33 && wc <= 7'd63) || wc >= 7'd95);
    if (mos) held_q = wc;
    for (int s = 0; s < 8; s++) begin
      sr = s[2:0];
      w.grow = dbl_q ? {lower_q, sr[2:1]} : sr;
      w.fg = fg_q;
      w.bg = bg_q;
      w.hide = flash_q && phase_q;
      w.mos = mos;
      w.pix = mos ? sixel_row(wc, w.grow, contig_q) : 8'd0;
      w.glyph = mos ? 7'd0 : wc;
      w.srow = sr;
      w.col = col_q;
      w.row = row_q;
      w.last = (s == 7);
      if (use_typed) begin
        w.fg = tv.fg;
        w.bg = tv.bg;
        w.mos = tv.mos;
        w.glyph = tv.glyph;
      end
      pending_words = {pending_words, w};
    end
    if (int'(col_q) + 1 >= COLUMNS) begin
      col_q = '0;
      lower_q = row_dbl_q ? !lower_q : 1'b0;
      clear_row_attrs();
      if (int'(row_q) + 1 >= ROWS) begin
        row_q = '0;
        lower_q = 1'b0;
      end else begin
        row_q = row_q + 1'b1;
      end
    end else begin
      col_q = col_q + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT)
        $display("mismatch on %s at row %0d column %0d scan %0d: expected %0d, got %0d",
                 name, exp_word.row, exp_word.col, exp_word.srow, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) phase_q = cfg_data;
      if (pop && !empty) begin
        got_word = '{fg_colour, bg_colour, hide_fore, use_mosaic, mosaic_row, glyph_code,
                     glyph_row, scan_row, cell_column, cell_row, last};
        if (pending_words.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("unexpected word at row %0d column %0d scan %0d",
                     cell_row, cell_column, scan_row);
        end else begin
          exp_word = pending_words.pop_front();
          check_field("fg_colour", exp_word.fg, got_word.fg);
          check_field("bg_colour", exp_word.bg, got_word.bg);
          check_field("hide_fore", exp_word.hide, got_word.hide);
          check_field("use_mosaic", exp_word.mos, got_word.mos);
          check_field("mosaic_row", exp_word.pix, got_word.pix);
          check_field("glyph_code", exp_word.glyph, got_word.glyph);
          check_field("glyph_row", exp_word.grow, got_word.grow);
          check_field("scan_row", exp_word.srow, got_word.srow);
          check_field("cell_column", exp_word.col, got_word.col);
          check_field("cell_row", exp_word.row, got_word.row);
          check_field("last", exp_word.last, got_word.last);
        end
      end
      if (push && !full) decode_char(char_byte, typed_en, typed_row);
    end
  end

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [7:0] rand_char();
    logic [7:0] r;
    r = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) r[6:5] = 2'b00;
    return r;
  endfunction

  task automatic send_char(input dir_row_t d);
    @(negedge clk);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    char_byte <= d.b;
    typed_en <= d.typed;
    typed_row <= d;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_flash(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    push = 1'b0;
    char_byte = 8'd0;
    pop = 1'b0;
    typed_en = 1'b0;
    typed_row = '0;
    mismatch_cnt = 0;
    send_idle = 0;
    recv_stall = 0;
    col_q = '0;
    row_q = '0;
    lower_q = 1'b0;
    phase_q = 1'b0;
    clear_row_attrs();
    send_pct = '{0, 66, 0, 36};
    recv_pct = '{0, 0, 66, 36};

    // The first rows run from the reset state, so their words are known outright.
    dir_tab = '{
      typed(8'h41, 3'd7, 3'd0, 7'd65),
      typed(8'h00, 3'd7, 3'd0, CHAR_SPACE),
      typed(8'hFF, 3'd7, 3'd0, 7'd127),
      typed(8'h20, 3'd7, 3'd0, CHAR_SPACE),
      plain(CODE_ALPHA_LO),
      plain(CODE_NEW_BG),
      plain(CODE_GFX_HI),
      plain(8'h7F),
      plain(CODE_SEPARATED),
      plain(8'h35),
      plain(8'h5F),
      plain(CODE_CONTIG),
      plain(8'h21),
      plain(CODE_HOLD),
      plain(CODE_GFX_BLACK),
      plain(CODE_BLACK_BG),
      plain(CODE_RELEASE),
      plain(8'h40),
      plain(CODE_FLASH),
      plain(8'h61),
      plain(CODE_STEADY),
      plain(CODE_CONCEAL),
      plain(8'h42),
      plain(CODE_ALPHA_HI),
      plain(CODE_DBL_ON),
      plain(8'h48),
      plain(CODE_DBL_OFF),
      plain(8'h1F),
      plain(CODE_ALPHA_BLACK)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_flash(1'b0);
    for (int i = 0; i < NDIR; i++) send_char(dir_tab[i]);

    for (int p = 0; p < 4; p++) begin
      drain();
      write_flash(p[0] == 1'b0);
      send_idle = send_pct[p];
      recv_stall = recv_pct[p];
      repeat (RANDOM_PER_PHASE) send_char(plain(rand_char()));
    end

    drain();
    if (mismatch_cnt == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
